// ===== src/page_table_map_insert_unit_macros.svh =====
// Assertion macros shared by the page table insert unit.
`ifndef PAGE_TABLE_MAP_INSERT_UNIT_MACROS_SVH
`define PAGE_TABLE_MAP_INSERT_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTMI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTMI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== src/ptmi_pkg.sv =====
// Constants shared by the page table insert unit and its channels.
`timescale 1ns / 1ps

package ptmi_pkg;

	localparam int POOL_TABLES   = 64;
	localparam int TABLE_ENTRIES = 512;
	localparam int LEVELS        = 4;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int VPAGE_W       = LEVELS * IDX_W;
	localparam int FRAME_W       = 40;
	localparam int ENTRY_W       = FRAME_W + 2;
	localparam int ENT_PRESENT   = FRAME_W;
	localparam int ENT_WRITABLE  = FRAME_W + 1;
	localparam int ENT_STALE     = ENTRY_W;
	localparam int STORE_W       = ENTRY_W + 1;
	localparam int TBL_W         = $clog2(POOL_TABLES);
	localparam int NEXT_W        = $clog2(POOL_TABLES + 1);
	localparam int ADDR_W        = TBL_W + IDX_W;
	localparam int STORE_DEPTH   = POOL_TABLES * TABLE_ENTRIES;
	localparam int ADDED_W       = 2;
	localparam int CFG_DATA_W    = 64;
	localparam int CFG_ADDR_W    = 4;
	localparam int CFG_SEL_BIT   = 3;

	localparam logic [FRAME_W-1:0] POOL_LIMIT     = FRAME_W'(POOL_TABLES);
	localparam logic [NEXT_W:0]    POOL_LIMIT_EXT = (NEXT_W + 1)'(POOL_TABLES);
	localparam logic [NEXT_W-1:0]  POOL_LIMIT_NF  = NEXT_W'(POOL_TABLES);
	localparam logic [NEXT_W-1:0]  NEXT_FREE_RST  = NEXT_W'(1);
	localparam logic [ADDR_W-1:0]  CLR_LAST       = ADDR_W'(STORE_DEPTH - 1);

	localparam logic [1:0] LEVEL_ROOT       = 2'd0;
	localparam logic [1:0] LEVEL_LAST_UPPER = 2'd2;
	localparam logic [1:0] LEVEL_LEAF       = 2'd3;

	localparam logic STATUS_MAPPED  = 1'b0;
	localparam logic STATUS_NO_POOL = 1'b1;

	localparam logic REG_POOL_BASE = 1'b0;

endpackage

// ===== src/ptmi_if.sv =====
// Request and response channel interfaces of the page table insert unit.
`timescale 1ns / 1ps

interface ptmi_in_if;
	logic                             valid;
	logic                             ready;
	logic [ptmi_pkg::VPAGE_W-1:0]     virtual_page;
	logic [ptmi_pkg::FRAME_W-1:0]     physical_frame;

	modport source (output valid, output virtual_page, output physical_frame, input ready);
	modport sink (input valid, input virtual_page, input physical_frame, output ready);
endinterface

interface ptmi_out_if;
	logic                             valid;
	logic                             ready;
	logic                             status;
	logic [ptmi_pkg::ADDED_W-1:0]     tables_added;

	modport source (output valid, output status, output tables_added, input ready);
	modport sink (input valid, input status, input tables_added, output ready);
endinterface

// ===== src/ptmi_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module ptmi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/page_table_map_insert_unit.sv =====
// Top level of the page table insert unit: walk sequencer, shared adder and table store.
//
//  channel   dir   handshake          word
//  map_req   in    valid / ready      virtual_page, physical_frame
//  map_rsp   out   valid / ready      status, tables_added
//  apb       in    psel, penable      pool_base_frame at byte address 0
//
// After reset a clearing pass writes all POOL_TABLES * 512 table store entries
// (32768 by default), and no word is accepted until it ends.
// A mapping walks through the single read port of the table store: one read per walked
// level, then one write per new table and one for the leaf, with the pointer sums done in
// one 40-bit adder. A new mapping is accepted only once the sequencer is back in idle.
// An error ends the walk early. A stalled response holds the sequencer in its last step.
`timescale 1ns / 1ps
`include "page_table_map_insert_unit_macros.svh"

module page_table_map_insert_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	ptmi_in_if.sink                            map_req,
	ptmi_out_if.source                         map_rsp,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [ptmi_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [ptmi_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [ptmi_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                               pready
);

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_READ  = 8'b0000_0100,
		ST_EVAL  = 8'b0000_1000,
		ST_CHECK = 8'b0001_0000,
		ST_LINK  = 8'b0010_0000,
		ST_LEAF  = 8'b0100_0000,
		ST_FIN   = 8'b1000_0000
	} state_t;

	state_t                              state_q;
	logic [ptmi_pkg::ADDR_W-1:0]         clr_q;
	logic [ptmi_pkg::FRAME_W-1:0]        base_q;
	logic [ptmi_pkg::VPAGE_W-1:0]        vpage_q;
	logic [ptmi_pkg::FRAME_W-1:0]        pframe_q;
	logic [1:0]                          level_q;
	logic [ptmi_pkg::TBL_W-1:0]          cur_q;
	logic [ptmi_pkg::NEXT_W-1:0]         next_free_q;
	logic [1:0]                          needed_q;
	logic                                err_q;
	logic                                out_valid_q;
	logic                                status_q;
	logic [ptmi_pkg::ADDED_W-1:0]        added_q;

	logic                                ram_we;
	logic [ptmi_pkg::ADDR_W-1:0]         ram_waddr;
	logic [ptmi_pkg::STORE_W-1:0]        ram_wdata;
	logic [ptmi_pkg::ADDR_W-1:0]         ram_raddr;
	logic [ptmi_pkg::STORE_W-1:0]        ram_rdata;

	logic [ptmi_pkg::FRAME_W-1:0]        alu_a;
	logic [ptmi_pkg::FRAME_W-1:0]        alu_b;
	logic                                alu_sub;
	logic [ptmi_pkg::FRAME_W-1:0]        alu_y;
	logic                                off_ok;
	logic                                ent_present;
	logic                                ent_stale;
	logic                                link_stale;
	logic                                leaf_stale;
	logic [1:0]                          needed;
	logic                                pool_short;
	logic                                req_acc;
	logic                                rsp_load;
	logic                                cfg_wr;

	function automatic logic [ptmi_pkg::IDX_W-1:0] level_idx(
		input logic [ptmi_pkg::VPAGE_W-1:0] vp,
		input logic [1:0]                   lvl
	);
		logic [ptmi_pkg::IDX_W-1:0] idx;
		case (lvl)
			2'd0:    idx = vp[3 * ptmi_pkg::IDX_W +: ptmi_pkg::IDX_W];
			2'd1:    idx = vp[2 * ptmi_pkg::IDX_W +: ptmi_pkg::IDX_W];
			2'd2:    idx = vp[ptmi_pkg::IDX_W +: ptmi_pkg::IDX_W];
			default: idx = vp[0 +: ptmi_pkg::IDX_W];
		endcase
		return idx;
	endfunction

	ptmi_ram #(
		.WIDTH (ptmi_pkg::STORE_W),
		.DEPTH (ptmi_pkg::STORE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		if (psel && paddr[ptmi_pkg::CFG_SEL_BIT] == ptmi_pkg::REG_POOL_BASE) begin
			prdata = ptmi_pkg::CFG_DATA_W'(base_q);
		end
	end

	// An entry written into a table that has not yet been handed out carries a stale mark.
	// Once that table is taken from the pool the marked entry reads as not present, so a
	// freshly taken table behaves as cleared.
	assign ent_stale   = ram_rdata[ptmi_pkg::ENT_STALE] && ({1'b0, cur_q} < next_free_q);
	assign ent_present = ram_rdata[ptmi_pkg::ENT_PRESENT] && !ent_stale;
	assign link_stale  = {1'b0, cur_q} > next_free_q;
	assign leaf_stale  = {1'b0, cur_q} >= next_free_q;

	// Shared adder: entry frame minus pool base during the walk, pool base plus
	// table number when a new table is linked in.
	always_comb begin
		alu_sub = (state_q == ST_EVAL);
		alu_a   = alu_sub ? ram_rdata[ptmi_pkg::FRAME_W-1:0] : base_q;
		alu_b   = alu_sub ? base_q : ptmi_pkg::FRAME_W'(next_free_q);
		alu_y   = alu_a + (alu_sub ? ~alu_b : alu_b) + ptmi_pkg::FRAME_W'(alu_sub);
	end

	assign off_ok     = alu_y < ptmi_pkg::POOL_LIMIT;
	assign needed     = ptmi_pkg::LEVEL_LEAF - level_q;
	assign pool_short = ({1'b0, next_free_q} + (ptmi_pkg::NEXT_W + 1)'(needed))
		> ptmi_pkg::POOL_LIMIT_EXT;

	always_comb begin
		ram_raddr = {ptmi_pkg::TBL_W'(0), level_idx(vpage_q, ptmi_pkg::LEVEL_ROOT)};
		if (state_q == ST_EVAL) begin
			ram_raddr = {alu_y[ptmi_pkg::TBL_W-1:0], level_idx(vpage_q, level_q + 2'd1)};
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_LINK: begin
				ram_we    = 1'b1;
				ram_waddr = {cur_q, level_idx(vpage_q, level_q)};
				ram_wdata = {link_stale, 2'b11, alu_y};
			end
			ST_LEAF: begin
				ram_we    = 1'b1;
				ram_waddr = {cur_q, level_idx(vpage_q, ptmi_pkg::LEVEL_LEAF)};
				ram_wdata = {leaf_stale, 2'b11, pframe_q};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign map_req.ready = (state_q == ST_IDLE);
	assign req_acc       = map_req.valid && map_req.ready;
	assign rsp_load      = (state_q == ST_FIN) && (!out_valid_q || map_rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			base_q      <= '0;
			level_q     <= ptmi_pkg::LEVEL_ROOT;
			cur_q       <= '0;
			next_free_q <= ptmi_pkg::NEXT_FREE_RST;
			needed_q    <= '0;
			err_q       <= 1'b0;
		end else begin
			if (cfg_wr && paddr[ptmi_pkg::CFG_SEL_BIT] == ptmi_pkg::REG_POOL_BASE) begin
				base_q <= pwdata[ptmi_pkg::FRAME_W-1:0];
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ptmi_pkg::CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_acc) begin
						level_q <= ptmi_pkg::LEVEL_ROOT;
						cur_q   <= '0;
						err_q   <= 1'b0;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (!ent_present) begin
						state_q <= ST_CHECK;
					end else if (!off_ok) begin
						err_q   <= 1'b1;
						state_q <= ST_FIN;
					end else begin
						cur_q   <= alu_y[ptmi_pkg::TBL_W-1:0];
						level_q <= level_q + 2'd1;
						if (level_q == ptmi_pkg::LEVEL_LAST_UPPER) begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					needed_q <= needed;
					if (pool_short) begin
						err_q   <= 1'b1;
						state_q <= ST_FIN;
					end else if (level_q == ptmi_pkg::LEVEL_LEAF) begin
						state_q <= ST_LEAF;
					end else begin
						state_q <= ST_LINK;
					end
				end
				ST_LINK: begin
					cur_q       <= next_free_q[ptmi_pkg::TBL_W-1:0];
					next_free_q <= next_free_q + 1'b1;
					level_q     <= level_q + 2'd1;
					if (level_q == ptmi_pkg::LEVEL_LAST_UPPER) begin
						state_q <= ST_LEAF;
					end
				end
				ST_LEAF: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			vpage_q  <= map_req.virtual_page;
			pframe_q <= map_req.physical_frame;
		end
		if (rsp_load) begin
			status_q <= err_q ? ptmi_pkg::STATUS_NO_POOL : ptmi_pkg::STATUS_MAPPED;
			added_q  <= err_q ? '0 : needed_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rsp_load) begin
			out_valid_q <= 1'b1;
		end else if (map_rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign map_rsp.valid        = out_valid_q;
	assign map_rsp.status       = status_q;
	assign map_rsp.tables_added = added_q;

	`PTMI_ASSERT_NOW(a_link_in_pool, clk, arst_n, state_q == ST_LINK, next_free_q < ptmi_pkg::POOL_LIMIT_NF, "table linked beyond the pool")
	`PTMI_ASSERT_NOW(a_link_upper_only, clk, arst_n, state_q == ST_LINK, level_q != ptmi_pkg::LEVEL_LEAF, "table linked at the leaf level")
	`PTMI_ASSERT_NEXT(a_clear_done, clk, arst_n, state_q == ST_CLEAR && clr_q == ptmi_pkg::CLR_LAST, state_q == ST_IDLE, "clearing pass did not end")
	`PTMI_ASSERT_NOW(a_err_no_tables, clk, arst_n, out_valid_q && status_q == ptmi_pkg::STATUS_NO_POOL, added_q == '0, "error word reports new tables")
	`PTMI_ASSERT_NOW(a_no_write_on_err, clk, arst_n, ram_we && state_q != ST_CLEAR, !err_q, "table store written after an error")

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the page table insert unit, built around a table walk predictor.
`timescale 1ns / 1ps

module testbench;
	import ptmi_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 1250;
	localparam logic [CFG_ADDR_W-1:0] POOL_BASE_ADDR = CFG_ADDR_W'(REG_POOL_BASE) << CFG_SEL_BIT;
	localparam logic [CFG_ADDR_W-1:0] UNMAPPED_ADDR  = CFG_ADDR_W'(1) << CFG_SEL_BIT;
	localparam logic [FRAME_W-1:0]    FRAME_MAX      = {FRAME_W{1'b1}};

	typedef struct packed {
		logic [VPAGE_W-1:0] page;
		logic               status;
		logic [ADDED_W-1:0] added;
	} map_outcome_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	ptmi_in_if  map_req_if ();
	ptmi_out_if map_rsp_if ();

	page_table_map_insert_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.map_req (map_req_if),
		.map_rsp (map_rsp_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	logic [ENTRY_W-1:0] tables_model [STORE_DEPTH];
	logic [NEXT_W-1:0]  next_table_model;
	logic [FRAME_W-1:0] pool_base_model;

	map_outcome_t       pending_outcomes [$];
	logic [VPAGE_W-1:0] known_pages [$];

	int  cycle_count;
	int  fail_count;
	int  mappings_sent;
	int  words_checked;
	int  refusals_seen;
	int  tables_granted;
	bit  calm;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d words outstanding.",
				cycle_count, pending_outcomes.size());
			$display("page_table_map_insert_unit verification failed");
			$finish;
		end
	end

	task automatic note_mismatch(input string msg);
		fail_count++;
		if (fail_count <= 40)
			$display("MISMATCH at %0t: %s", $realtime, msg);
	endtask

	function automatic bit take_break();
		return !calm && ($urandom_range(0, 99) < 18);
	endfunction

	always @(negedge clk) begin
		map_rsp_if.ready = !take_break();
	end

	always @(posedge clk) begin
		map_outcome_t want;
		if (arst_n && map_rsp_if.valid && map_rsp_if.ready) begin
			if (pending_outcomes.size() == 0) begin
				note_mismatch($sformatf("response with nothing pending, status %0b added %0d",
					map_rsp_if.status, map_rsp_if.tables_added));
			end else begin
				want = pending_outcomes.pop_front();
				words_checked++;
				if (map_rsp_if.status == STATUS_NO_POOL)
					refusals_seen++;
				if (map_rsp_if.status !== want.status)
					note_mismatch($sformatf("page %h: status %b, expected %b",
						want.page, map_rsp_if.status, want.status));
				if (map_rsp_if.tables_added !== want.added)
					note_mismatch($sformatf("page %h: tables_added %0d, expected %0d",
						want.page, map_rsp_if.tables_added, want.added));
			end
		end
	end

	function automatic logic [IDX_W-1:0] level_idx(input logic [VPAGE_W-1:0] vp, input int lvl);
		return IDX_W'(vp >> (IDX_W * (LEVELS - 1 - lvl)));
	endfunction

	function automatic logic [VPAGE_W-1:0] make_page(input logic [IDX_W-1:0] i0,
			input logic [IDX_W-1:0] i1, input logic [IDX_W-1:0] i2, input logic [IDX_W-1:0] i3);
		return {i0, i1, i2, i3};
	endfunction

	// Follows present entries and returns the number of missing levels, or -1 when a
	// present entry points outside the pool. The last table reached is returned too.
	function automatic int walk_existing(input logic [VPAGE_W-1:0] vp, output int last_tbl);
		logic [ENTRY_W-1:0] ent;
		logic [FRAME_W-1:0] off;
		last_tbl = 0;
		for (int lvl = 0; lvl < LEVELS - 1; lvl++) begin
			ent = tables_model[last_tbl * TABLE_ENTRIES + level_idx(vp, lvl)];
			if (!ent[ENT_PRESENT])
				return LEVELS - 1 - lvl;
			off = ent[FRAME_W-1:0] - pool_base_model;
			if (off >= POOL_LIMIT)
				return -1;
			last_tbl = int'(off);
		end
		return 0;
	endfunction

	function automatic map_outcome_t insert_mapping(input logic [VPAGE_W-1:0] vp,
			input logic [FRAME_W-1:0] pf);
		map_outcome_t res;
		int           missing;
		int           cur;
		int           fresh_tbl;
		res.page   = vp;
		res.status = STATUS_NO_POOL;
		res.added  = '0;
		missing = walk_existing(vp, cur);
		if (missing < 0 || int'(next_table_model) + missing > POOL_TABLES)
			return res;
		for (int lvl = LEVELS - 1 - missing; lvl < LEVELS - 1; lvl++) begin
			fresh_tbl = int'(next_table_model);
			next_table_model++;
			for (int i = 0; i < TABLE_ENTRIES; i++)
				tables_model[fresh_tbl * TABLE_ENTRIES + i] = '0;
			tables_model[cur * TABLE_ENTRIES + level_idx(vp, lvl)] =
				{2'b11, pool_base_model + FRAME_W'(fresh_tbl)};
			cur = fresh_tbl;
		end
		tables_model[cur * TABLE_ENTRIES + level_idx(vp, int'(LEVEL_LEAF))] = {2'b11, pf};
		res.status = STATUS_MAPPED;
		res.added  = ADDED_W'(missing);
		tables_granted += missing;
		known_pages.push_back(vp);
		return res;
	endfunction

	// Copies the top indices of a page mapped earlier and randomises the rest.
	function automatic logic [VPAGE_W-1:0] pick_page(input int shared);
		logic [VPAGE_W-1:0] fresh;
		logic [VPAGE_W-1:0] base_pg;
		logic [VPAGE_W-1:0] keep;
		fresh = VPAGE_W'({$urandom, $urandom});
		if (known_pages.size() == 0 || shared == 0)
			return fresh;
		base_pg = known_pages[$urandom_range(0, known_pages.size() - 1)];
		keep = {VPAGE_W{1'b1}} << (IDX_W * (LEVELS - shared));
		return (base_pg & keep) | (fresh & ~keep);
	endfunction

	function automatic logic [VPAGE_W-1:0] page_needing(input int want);
		logic [VPAGE_W-1:0] vp;
		int                 last_tbl;
		vp = '0;
		for (int tries = 0; tries < 500; tries++) begin
			vp = pick_page(LEVELS - 1 - want);
			if (walk_existing(vp, last_tbl) == want)
				return vp;
		end
		return vp;
	endfunction

	function automatic logic [FRAME_W-1:0] pick_frame();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		if (r < 16)
			return FRAME_MAX;
		return FRAME_W'({$urandom, $urandom});
	endfunction

	task automatic send_map(input logic [VPAGE_W-1:0] vp, input logic [FRAME_W-1:0] pf);
		@(negedge clk);
		while (take_break()) begin
			map_req_if.valid = 1'b0;
			@(negedge clk);
		end
		pending_outcomes.push_back(insert_mapping(vp, pf));
		map_req_if.valid          = 1'b1;
		map_req_if.virtual_page   = vp;
		map_req_if.physical_frame = pf;
		mappings_sent++;
		@(posedge clk);
		while (!map_req_if.ready)
			@(posedge clk);
	endtask

	task automatic drain_responses();
		@(negedge clk);
		map_req_if.valid = 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = addr;
		pwdata  = data;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (addr == POOL_BASE_ADDR)
			pool_base_model = data[FRAME_W-1:0];
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic cfg_check();
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = POOL_BASE_ADDR;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== CFG_DATA_W'(pool_base_model))
			note_mismatch($sformatf("pool_base_frame reads %h, expected %h",
				prdata, pool_base_model));
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	task automatic set_pool_base(input logic [CFG_DATA_W-1:0] data);
		drain_responses();
		cfg_write(POOL_BASE_ADDR, data);
		cfg_check();
	endtask

	task automatic test_register_access();
		cfg_check();
		cfg_write(UNMAPPED_ADDR, {$urandom, $urandom});
		cfg_check();
		cfg_write(POOL_BASE_ADDR, {$urandom, $urandom});
		cfg_check();
		cfg_write(POOL_BASE_ADDR, '0);
		cfg_check();
	endtask

	task automatic test_table_walks();
		send_map(make_page(9'h000, 9'h000, 9'h000, 9'h000), '0);
		send_map(make_page(9'h1ff, 9'h1ff, 9'h1ff, 9'h1ff), FRAME_MAX);
		send_map(make_page(9'h000, 9'h1ff, 9'h000, 9'h000), pick_frame());
		send_map(make_page(9'h000, 9'h000, 9'h1ff, 9'h155), pick_frame());
		send_map(make_page(9'h000, 9'h000, 9'h000, 9'h1ff), pick_frame());
		// Rewrites a leaf that is already present.
		send_map(make_page(9'h000, 9'h000, 9'h000, 9'h000), 40'hA5_A5A5_A5A5);
	endtask

	task automatic test_foreign_pointers();
		// Upper data bits are set and must be dropped by the register.
		set_pool_base(64'hFFFF_FF00_0000_0003);
		send_map(make_page(9'h000, 9'h000, 9'h000, 9'h000), pick_frame());
		send_map(page_needing(3), pick_frame());
		set_pool_base({CFG_DATA_W{1'b1}});
		send_map(page_needing(3), pick_frame());
		send_map(make_page(9'h1ff, 9'h1ff, 9'h1ff, 9'h000), pick_frame());
		set_pool_base('0);
		send_map(make_page(9'h000, 9'h000, 9'h000, 9'h000), pick_frame());
	endtask

	task automatic test_random_mappings();
		logic [CFG_DATA_W-1:0] phase_base [4];
		int                    phase_len [4];
		int                    r;
		phase_base[0] = '0;
		phase_base[1] = CFG_DATA_W'($urandom_range(1, 4));
		phase_base[2] = {$urandom, $urandom};
		phase_base[3] = '0;
		phase_len[0]  = RANDOM_ITEMS * 36 / 100;
		phase_len[1]  = RANDOM_ITEMS * 20 / 100;
		phase_len[2]  = RANDOM_ITEMS * 8 / 100;
		phase_len[3]  = RANDOM_ITEMS - phase_len[0] - phase_len[1] - phase_len[2];
		for (int ph = 0; ph < 4; ph++) begin
			set_pool_base(phase_base[ph]);
			for (int n = 0; n < phase_len[ph]; n++) begin
				calm = (ph == 0) && (n >= 100) && (n < 350);
				r = $urandom_range(0, 99);
				if (r < 15)
					send_map(pick_page(4), pick_frame());
				else if (r < 65)
					send_map(pick_page(3), pick_frame());
				else if (r < 77)
					send_map(pick_page(2), pick_frame());
				else if (r < 85)
					send_map(pick_page(1), pick_frame());
				else
					send_map(pick_page(0), pick_frame());
			end
			calm = 1'b0;
		end
	endtask

	task automatic test_pool_exhaustion();
		int room;
		set_pool_base('0);
		// Fill what is left of the pool, ending exactly on its last table.
		for (int n = 0; n < 40 && int'(next_table_model) < POOL_TABLES; n++) begin
			room = POOL_TABLES - int'(next_table_model);
			send_map(page_needing(room < 3 ? room : 3), pick_frame());
		end
		send_map(page_needing(1), pick_frame());
		send_map(page_needing(2), pick_frame());
		send_map(page_needing(3), pick_frame());
		send_map(page_needing(0), pick_frame());
	endtask

	initial begin
		foreach (tables_model[i])
			tables_model[i] = '0;
		next_table_model          = NEXT_FREE_RST;
		pool_base_model           = '0;
		calm                      = 1'b0;
		arst_n                    = 1'b0;
		psel                      = 1'b0;
		penable                   = 1'b0;
		pwrite                    = 1'b0;
		paddr                     = '0;
		pwdata                    = '0;
		map_req_if.valid          = 1'b0;
		map_req_if.virtual_page   = '0;
		map_req_if.physical_frame = '0;
		map_rsp_if.ready          = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_register_access();
		test_table_walks();
		test_foreign_pointers();
		test_random_mappings();
		test_pool_exhaustion();
		drain_responses();

		$display("Sent %0d mappings across five pool base settings; %0d responses checked.",
			mappings_sent, words_checked);
		$display("%0d mappings were refused and %0d tables were handed out of the pool.",
			refusals_seen, tables_granted);
		if (fail_count == 0) begin
			$display("page_table_map_insert_unit verification clean");
		end else begin
			$display("%0d mismatches in total.", fail_count);
			$display("page_table_map_insert_unit verification failed");
		end
		$finish;
	end

endmodule
